FILE: rtl/csd_pkg.sv
// Package for the card CSD register decoder: payload structs, layout codes
// and the mantissa and exponent tables used by the decode stages.
// Depends on nothing; every other file but csd_stream_if imports it.
package csd_pkg;

    localparam logic [1:0] VER_SD_STD = 2'd0;
    localparam logic [1:0] VER_SD_HC  = 2'd1;
    localparam logic [1:0] VER_MMC_1  = 2'd1;
    localparam logic [1:0] VER_MMC_2  = 2'd2;

    localparam logic [3:0] CAP_SHIFT_HC  = 4'd10;
    localparam logic [3:0] CAP_SHIFT_STD = 4'd2;
    localparam logic [3:0] HC_BLOCK_BITS = 4'd9;
    localparam logic [2:0] HC_SPEED      = 3'd4;
    localparam logic [14:0] CLK_PER_UNIT = 15'd100;

    typedef enum logic [1:0] {
        KIND_BAD = 2'd0,
        KIND_STD = 2'd1,
        KIND_HC  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [63:0] raw_high;
        logic [63:0] raw_low;
    } t_in_data;

    typedef struct packed {
        logic        bad_structure;
        logic [3:0]  spec_version;
        logic [26:0] access_time_ns;
        logic [14:0] access_time_clocks;
        logic [29:0] max_rate;
        logic [11:0] command_classes;
        logic [32:0] capacity_blocks;
        logic [3:0]  read_block_bits;
        logic [3:0]  write_block_bits;
        logic [2:0]  write_speed_factor;
        logic [3:0]  access_flags;
    } t_out_data;

    typedef struct packed {
        logic        bad;
        logic [3:0]  spec;
        logic [19:0] time_tenth;
        logic [6:0]  time_mant;
        logic        time_small;
        logic [3:0]  time_ceil;
        logic [7:0]  clk_byte;
        logic [23:0] rate_exp;
        logic [6:0]  rate_mant;
        logic [11:0] ccc;
        logic [21:0] cap_mant;
        logic [3:0]  cap_shift;
        logic [3:0]  rbl;
        logic [3:0]  wbl;
        logic [2:0]  wsf;
        logic [3:0]  flags;
    } t_s1;

    typedef struct packed {
        logic        bad;
        logic [3:0]  spec;
        logic [26:0] time_prod;
        logic        time_small;
        logic [3:0]  time_ceil;
        logic [14:0] clocks;
        logic [29:0] rate;
        logic [11:0] ccc;
        logic [21:0] cap_mant;
        logic [3:0]  cap_shift;
        logic [3:0]  rbl;
        logic [3:0]  wbl;
        logic [2:0]  wsf;
        logic [3:0]  flags;
    } t_s2;

    function automatic logic [6:0] mant_val(input logic [3:0] code);
        logic [6:0] v;
        case (code)
            4'd0: v = 7'd0;
            4'd1: v = 7'd10;
            4'd2: v = 7'd12;
            4'd3: v = 7'd13;
            4'd4: v = 7'd15;
            4'd5: v = 7'd20;
            4'd6: v = 7'd25;
            4'd7: v = 7'd30;
            4'd8: v = 7'd35;
            4'd9: v = 7'd40;
            4'd10: v = 7'd45;
            4'd11: v = 7'd50;
            4'd12: v = 7'd55;
            4'd13: v = 7'd60;
            4'd14: v = 7'd70;
            4'd15: v = 7'd80;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

    // Mantissa plus nine, divided by ten, for the unit time exponent.
    function automatic logic [3:0] ceil_val(input logic [3:0] code);
        logic [3:0] v;
        case (code)
            4'd0: v = 4'd0;
            4'd1: v = 4'd1;
            4'd2: v = 4'd2;
            4'd3: v = 4'd2;
            4'd4: v = 4'd2;
            4'd5: v = 4'd2;
            4'd6: v = 4'd3;
            4'd7: v = 4'd3;
            4'd8: v = 4'd4;
            4'd9: v = 4'd4;
            4'd10: v = 4'd5;
            4'd11: v = 4'd5;
            4'd12: v = 4'd6;
            4'd13: v = 4'd6;
            4'd14: v = 4'd7;
            4'd15: v = 4'd8;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    // Time exponent divided by ten; the unit exponent takes the ceiling path.
    function automatic logic [19:0] time_tenth(input logic [2:0] code);
        logic [19:0] v;
        case (code)
            3'd0: v = 20'd0;
            3'd1: v = 20'd1;
            3'd2: v = 20'd10;
            3'd3: v = 20'd100;
            3'd4: v = 20'd1000;
            3'd5: v = 20'd10000;
            3'd6: v = 20'd100000;
            3'd7: v = 20'd1000000;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

    function automatic logic [23:0] rate_exp_val(input logic [2:0] code);
        logic [23:0] v;
        case (code)
            3'd0: v = 24'd10000;
            3'd1: v = 24'd100000;
            3'd2: v = 24'd1000000;
            3'd3: v = 24'd10000000;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/csd_stream_if.sv
// Valid/ready channel carrying one payload of type T per transfer.
// Depends on nothing; the payload type is given at instantiation.
interface csd_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/csd_extract.sv
// First pipeline stage: version check, field extraction and table lookups.
// Depends on csd_pkg.
module csd_extract
    import csd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_card_is_mmc,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_data i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_s1      o_data
);

    logic         r_valid;
    t_s1          r_data;
    t_s1          n_data;
    t_kind        kind;
    logic [127:0] raw;
    logic [1:0]   ver;

    assign raw = {i_data.raw_high, i_data.raw_low};
    assign ver = raw[127:126];

    always_comb begin
        if (i_card_is_mmc) begin
            kind = (ver == VER_MMC_1 || ver == VER_MMC_2) ? KIND_STD : KIND_BAD;
        end else if (ver == VER_SD_STD) begin
            kind = KIND_STD;
        end else if (ver == VER_SD_HC) begin
            kind = KIND_HC;
        end else begin
            kind = KIND_BAD;
        end
    end

    always_comb begin
        n_data = '0;
        case (kind)
            KIND_STD: begin
                n_data.spec       = i_card_is_mmc ? raw[125:122] : 4'd0;
                n_data.time_tenth = time_tenth(raw[114:112]);
                n_data.time_mant  = mant_val(raw[118:115]);
                n_data.time_small = (raw[114:112] == 3'd0);
                n_data.time_ceil  = ceil_val(raw[118:115]);
                n_data.clk_byte   = raw[111:104];
                n_data.cap_mant   = {10'd0, raw[73:62]};
                n_data.cap_shift  = {1'b0, raw[49:47]} + CAP_SHIFT_STD;
                n_data.rbl        = raw[83:80];
                n_data.wbl        = raw[25:22];
                n_data.wsf        = raw[28:26];
                n_data.flags      = {raw[21], raw[77], raw[78], raw[79]};
                n_data.rate_exp   = rate_exp_val(raw[98:96]);
                n_data.rate_mant  = mant_val(raw[102:99]);
                n_data.ccc        = raw[95:84];
            end
            KIND_HC: begin
                n_data.cap_mant  = raw[69:48];
                n_data.cap_shift = CAP_SHIFT_HC;
                n_data.rbl       = HC_BLOCK_BITS;
                n_data.wbl       = HC_BLOCK_BITS;
                n_data.wsf       = HC_SPEED;
                n_data.rate_exp  = rate_exp_val(raw[98:96]);
                n_data.rate_mant = mant_val(raw[102:99]);
                n_data.ccc       = raw[95:84];
            end
            default: begin
                n_data.bad = 1'b1;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: rtl/csd_mult.sv
// Second pipeline stage: access time, clock count and rate products.
// Depends on csd_pkg.
module csd_mult
    import csd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s1  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_s2  o_data
);

    logic        r_valid;
    t_s2         r_data;
    t_s2         n_data;
    logic [29:0] rate_prod;

    assign rate_prod = 30'(i_data.rate_exp) * 30'(i_data.rate_mant);

    always_comb begin
        n_data            = '0;
        n_data.bad        = i_data.bad;
        n_data.spec       = i_data.spec;
        n_data.time_prod  = 27'(i_data.time_tenth) * 27'(i_data.time_mant);
        n_data.time_small = i_data.time_small;
        n_data.time_ceil  = i_data.time_ceil;
        n_data.clocks     = 15'(i_data.clk_byte) * CLK_PER_UNIT;
        n_data.rate       = rate_prod;
        n_data.ccc        = i_data.ccc;
        n_data.cap_mant   = i_data.cap_mant;
        n_data.cap_shift  = i_data.cap_shift;
        n_data.rbl        = i_data.rbl;
        n_data.wbl        = i_data.wbl;
        n_data.wsf        = i_data.wsf;
        n_data.flags      = i_data.flags;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: rtl/csd_format.sv
// Third pipeline stage: capacity shift, access time selection and the
// output register. Depends on csd_pkg.
module csd_format
    import csd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_s2       i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_data o_data
);

    logic        r_valid;
    t_out_data   r_data;
    t_out_data   n_data;
    logic [22:0] cap_plus;

    assign cap_plus = {1'b0, i_data.cap_mant} + 23'd1;

    always_comb begin
        n_data                    = '0;
        n_data.bad_structure      = i_data.bad;
        n_data.spec_version       = i_data.spec;
        n_data.access_time_ns     = i_data.time_small ? 27'(i_data.time_ceil)
                                                      : i_data.time_prod;
        n_data.access_time_clocks = i_data.clocks;
        n_data.max_rate           = i_data.rate;
        n_data.command_classes    = i_data.ccc;
        n_data.capacity_blocks    = i_data.bad ? 33'd0
                                               : (33'(cap_plus) << i_data.cap_shift);
        n_data.read_block_bits    = i_data.rbl;
        n_data.write_block_bits   = i_data.wbl;
        n_data.write_speed_factor = i_data.wsf;
        n_data.access_flags       = i_data.flags;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: rtl/card_csd_register_decoder.sv
// Card CSD register decoder, top level.
// Depends on csd_pkg, csd_stream_if, csd_extract, csd_mult and csd_format.
//
// i_in carries one 128-bit CSD response per transfer (raw_high, raw_low).
// o_out carries the decoded fields, one result for every response.
// i_cfg writes the card_is_mmc bit: 1 selects MMC rules, 0 SD rules. It is
// always ready and should only be written while no response is in flight.
// The decode runs through three register stages: extraction and table
// lookups, the time and rate products, then capacity and output select.
// An accepted response passes through the extract, mult and format stage
// registers in that order before it is presented on o_out; one response can
// be taken every cycle while o_out does not stall.
// Each stage holds its data while the next one stalls; a stage with no
// valid data still accepts, so bubbles close up behind a stalled o_out.
// With o_out ready, i_in is ready.
// Synchronous reset empties every stage and clears card_is_mmc to SD rules.
module card_csd_register_decoder
    import csd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    csd_stream_if.sink          i_in,
    csd_stream_if.sink          i_cfg,
    csd_stream_if.source        o_out
);

    logic r_card_is_mmc;
    logic s1_valid;
    logic s1_ready;
    t_s1  s1_data;
    logic s2_valid;
    logic s2_ready;
    t_s2  s2_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card_is_mmc <= 1'b0;
        end else if (i_cfg.valid) begin
            r_card_is_mmc <= i_cfg.data;
        end
    end

    csd_extract u_extract (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_card_is_mmc (r_card_is_mmc),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_data        (i_in.data),
        .o_valid       (s1_valid),
        .i_ready       (s1_ready),
        .o_data        (s1_data)
    );

    csd_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    csd_format u_format (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (o_out.data)
    );

`ifndef SYNTHESIS
    a_bad_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.bad_structure) |->
            (o_out.data.capacity_blocks == 33'd0 && o_out.data.max_rate == 30'd0 &&
             o_out.data.read_block_bits == 4'd0 && o_out.data.access_time_ns == 27'd0))
        else $error("bad structure result carries non-zero fields");

    a_capacity_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.bad_structure) |->
            (o_out.data.capacity_blocks != 33'd0))
        else $error("decoded capacity is zero");

    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.ready |-> i_in.ready)
        else $error("input not ready while output is ready");

    a_spec_implies_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.spec_version != 4'd0) |->
            !o_out.data.bad_structure)
        else $error("spec version set on a bad structure result");
`endif

endmodule
